// ===== sv/sha384_pkg.sv =====
// SHA-384 package: round constants, initial hash value and round/schedule functions.
package sha384_pkg;

  localparam int unsigned WordWidth  = 64;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned StateWords = 8;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [$clog2(Rounds)-1:0] round_t;
  typedef logic [$clog2(BlockWords)-1:0] wcnt_t;
  typedef logic [$clog2(StateWords)-1:0] sidx_t;

  localparam round_t LastRound = round_t'(Rounds - 1);
  localparam wcnt_t  LastWord  = wcnt_t'(BlockWords - 1);

  // SHA-512 round constants
  localparam word_t RoundK [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  // SHA-384 initial hash value
  localparam word_t InitHash [StateWords] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== sv/sha384_block_hash.sv =====
// SHA-384 block hash core: word loader, iterative round unit and digest emitter.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_stall_o | message_word_i, first_block_i, last_block_i
//  out     | output    | out_valid_o / out_stall_i | digest_word_o, word_index_o, last_word_o
//
// The core accepts one message word per cycle while in_stall_o is low. The sixteenth
// word of a block starts the compression: all 80 rounds run in the single round unit
// (schedule expansion runs alongside in the 16-word shift window), then the working
// variables are folded into the chain value. After a final block DIGEST_WORDS words
// leave at one per cycle unless stalled. in_stall_o is high from the start of
// compression until the chain update, or after a final block the last digest transfer.
// rst_ni clears the control state and loads the SHA-384 initial hash value.
module sha384_block_hash #(
  parameter int unsigned DIGEST_WORDS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sha384_pkg::word_t    message_word_i,
  input  logic                 first_block_i,
  input  logic                 last_block_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sha384_pkg::word_t    digest_word_o,
  output logic [2:0]           word_index_o,
  output logic                 last_word_o
);
  import sha384_pkg::*;

  localparam sidx_t LastIdx = sidx_t'(DIGEST_WORDS - 1);

  typedef enum logic [1:0] {
    StIdle,
    StRound,
    StUpdate,
    StEmit
  } state_e;

  state_e state_q;
  wcnt_t  wcnt_q;
  round_t round_q;
  sidx_t  idx_q;
  logic   last_q;
  word_t  chain_q [StateWords];
  word_t  v_q [StateWords];
  word_t  w_q [BlockWords];

  logic   in_xfer;
  logic   out_xfer;
  word_t  sched_new;
  word_t  t1;
  word_t  t2;

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StEmit);
  assign out_xfer   = out_valid_o && !out_stall_i;

  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = 3'(idx_q);
  assign last_word_o   = out_valid_o && (idx_q == LastIdx);

  // Round unit and schedule expansion
  always_comb begin
    sched_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
    t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
         + RoundK[round_q] + w_q[0];
    t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);
  end

  // Sequencer, counters and chain value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wcnt_q  <= '0;
      round_q <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < StateWords; i++) begin
        chain_q[i] <= InitHash[i];
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_xfer) begin
            wcnt_q <= wcnt_q + 1'b1;
            if (wcnt_q == '0 && first_block_i) begin
              for (int i = 0; i < StateWords; i++) begin
                chain_q[i] <= InitHash[i];
              end
            end
            if (wcnt_q == LastWord) begin
              last_q  <= last_block_i;
              state_q <= StRound;
            end
          end
        end
        StRound: begin
          if (round_q == LastRound) begin
            round_q <= '0;
            state_q <= StUpdate;
          end else begin
            round_q <= round_q + 1'b1;
          end
        end
        StUpdate: begin
          for (int i = 0; i < StateWords; i++) begin
            chain_q[i] <= chain_q[i] + v_q[i];
          end
          idx_q   <= '0;
          state_q <= last_q ? StEmit : StIdle;
        end
        StEmit: begin
          if (out_xfer) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == LastIdx) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Schedule window and working variables
  always_ff @(posedge clk_i) begin
    if (in_xfer || state_q == StRound) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BlockWords-1] <= in_xfer ? message_word_i : sched_new;
    end
    if (in_xfer && wcnt_q == LastWord) begin
      for (int i = 0; i < StateWords; i++) begin
        v_q[i] <= chain_q[i];
      end
    end else if (state_q == StRound) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // Checks
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("digest output while input is open");

  a_round_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StRound |-> round_q == '0)
    else $error("round counter not at zero outside compression");

  a_block_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && wcnt_q == LastWord) |=> (state_q == StRound && wcnt_q == '0))
    else $error("sixteenth word did not start compression");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_word_o) |=> !out_valid_o)
    else $error("digest output continues past its last word");

endmodule
